// ----- sv/cannm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cannm_pkg
// Types, codes and constants shared by the CAN network-management controller.
// ----------------------------------------------------------------------------
package cannm_pkg;

	localparam logic [10:0] NM_ID_BASE = 11'd1280;
	localparam logic [10:0] NM_ID_MASK = 11'd1792;

	localparam logic [7:0] CBV_REPEAT_BIT = 8'h01;
	localparam logic [7:0] CBV_WAKEUP_BIT = 8'h10;

	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_MAIN   = 3'd1;
	localparam logic [2:0] KIND_REQ    = 3'd2;
	localparam logic [2:0] KIND_REL    = 3'd3;
	localparam logic [2:0] KIND_RX     = 3'd4;
	localparam logic [2:0] KIND_INIT   = 3'd5;
	localparam logic [2:0] KIND_DEINIT = 3'd6;

	localparam logic [2:0] ST_UNINIT = 3'd0;
	localparam logic [2:0] ST_SLEEP  = 3'd1;
	localparam logic [2:0] ST_PREP   = 3'd2;
	localparam logic [2:0] ST_REPEAT = 3'd3;
	localparam logic [2:0] ST_NORMAL = 3'd4;
	localparam logic [2:0] ST_READY  = 3'd5;

	localparam logic [1:0] MD_SLEEP = 2'd0;
	localparam logic [1:0] MD_PREP  = 2'd1;
	localparam logic [1:0] MD_NET   = 2'd2;

	localparam logic [2:0] CFG_OWN_NODE_ID       = 3'd0;
	localparam logic [2:0] CFG_TIMEOUT_TICKS     = 3'd1;
	localparam logic [2:0] CFG_REPEAT_TICKS      = 3'd2;
	localparam logic [2:0] CFG_WAIT_SLEEP_TICKS  = 3'd3;
	localparam logic [2:0] CFG_CYCLE_TICKS       = 3'd4;
	localparam logic [2:0] CFG_START_DELAY_TICKS = 3'd5;
	localparam logic [2:0] CFG_FAST_SEND_COUNT   = 3'd6;
	localparam logic [2:0] CFG_FAST_CYCLE_TICKS  = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  own_node_id;
		logic [15:0] timeout_ticks;
		logic [15:0] repeat_ticks;
		logic [15:0] wait_sleep_ticks;
		logic [15:0] cycle_ticks;
		logic [15:0] start_delay_ticks;
		logic [7:0]  fast_send_count;
		logic [15:0] fast_cycle_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		own_node_id:       8'd1,
		timeout_ticks:     16'd2000,
		repeat_ticks:      16'd1500,
		wait_sleep_ticks:  16'd2000,
		cycle_ticks:       16'd1000,
		start_delay_ticks: 16'd100,
		fast_send_count:   8'd3,
		fast_cycle_ticks:  16'd20
	};

	typedef struct packed {
		logic [2:0]  state;
		logic [1:0]  mode;
		logic        req;
		logic        rrep;
		logic        first;
		logic [15:0] tmo;
		logic [15:0] rpt;
		logic [15:0] wsl;
		logic [15:0] cyc;
		logic [7:0]  fast;
		logic [7:0]  cbv;
	} st_t;

	localparam st_t ST_RESET_VAL = '{
		state: ST_SLEEP,
		mode:  MD_SLEEP,
		req:   1'b0,
		rrep:  1'b0,
		first: 1'b1,
		tmo:   16'd0,
		rpt:   16'd0,
		wsl:   16'd0,
		cyc:   16'd0,
		fast:  8'd0,
		cbv:   8'd0
	};

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_cbv;
		logic [2:0] nm_state;
		logic [1:0] nm_mode;
		logic       net_requested;
		logic       sleep_indication;
		logic       network_mode_indication;
		logic       last;
	} res_t;

	typedef struct packed {
		logic en;
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

endpackage
`default_nettype wire

// ----- sv/cannm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cannm_if
// Event, result and configuration channels of the network-management block.
// ----------------------------------------------------------------------------
interface cannm_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [10:0] can_id;
	logic [7:0]  rx_node_id;
	logic [7:0]  rx_cbv;

	modport source (output valid, kind, can_id, rx_node_id, rx_cbv, input ready);
	modport sink   (input valid, kind, can_id, rx_node_id, rx_cbv, output ready);
endinterface

interface cannm_res_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_cbv;
	logic [2:0] nm_state;
	logic [1:0] nm_mode;
	logic       net_requested;
	logic       sleep_indication;
	logic       network_mode_indication;
	logic       last;

	modport source (output valid, tx_valid, tx_cbv, nm_state, nm_mode, net_requested,
		sleep_indication, network_mode_indication, last, input ready);
	modport sink   (input valid, tx_valid, tx_cbv, nm_state, nm_mode, net_requested,
		sleep_indication, network_mode_indication, last, output ready);
endinterface

interface cannm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/cannm_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cannm_core
// NM state, timers and control bits; one registered update per accepted event
// with up to two results handed to the result queue.
// ----------------------------------------------------------------------------
module cannm_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 fire,
	input  wire  [2:0]          kind,
	input  wire  [10:0]         can_id,
	input  wire  [7:0]          rx_node_id,
	input  wire  [7:0]          rx_cbv,
	input  cannm_pkg::cfg_t     cfg,
	output cannm_pkg::push_t    push
);
	import cannm_pkg::*;

	st_t        st_q;
	st_t        n;
	res_t       r0;
	res_t       r1;
	logic [1:0] cnt;
	logic       en;
	logic [2:0] tgt;
	logic       put_en;
	logic       ind_s;
	logic       ind_n;
	logic       rep;

	function automatic res_t send_res(input st_t s);
		res_t r;
		r = '0;
		r.tx_valid      = 1'b1;
		r.tx_cbv        = s.cbv;
		r.nm_state      = s.state;
		r.nm_mode       = s.mode;
		r.net_requested = s.req;
		return r;
	endfunction

	function automatic st_t enter_state(input st_t s0, input cfg_t c, input logic [2:0] t);
		st_t s;
		s = s0;
		s.state = t;
		case (t)
			ST_SLEEP: begin
				s.mode = MD_SLEEP;
				s.cyc  = '0;
				s.wsl  = '0;
				s.tmo  = '0;
				s.rpt  = '0;
				s.fast = '0;
			end
			ST_PREP: begin
				s.mode = MD_PREP;
				s.wsl  = c.wait_sleep_ticks;
				s.cyc  = '0;
				s.fast = '0;
			end
			ST_REPEAT: begin
				s.mode   = MD_NET;
				s.rpt    = c.repeat_ticks;
				s.tmo    = c.timeout_ticks;
				s.cbv[4] = s.req;
				s.cbv[0] = s.rrep;
				s.rrep   = 1'b0;
				if (s.first) begin
					s.cyc   = c.start_delay_ticks;
					s.fast  = c.fast_send_count;
					s.first = 1'b0;
				end else begin
					s.cyc = c.cycle_ticks;
				end
			end
			ST_NORMAL: begin
				s.mode   = MD_NET;
				s.tmo    = c.timeout_ticks;
				s.cyc    = c.cycle_ticks;
				s.cbv[0] = 1'b0;
			end
			ST_READY: begin
				s.mode   = MD_NET;
				s.tmo    = c.timeout_ticks;
				s.cyc    = '0;
				s.cbv[0] = 1'b0;
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	always_comb begin
		n      = st_q;
		r0     = '0;
		r1     = '0;
		cnt    = 2'd0;
		en     = 1'b0;
		tgt    = ST_SLEEP;
		put_en = 1'b0;
		ind_s  = 1'b0;
		ind_n  = 1'b0;
		rep    = rx_cbv[0];

		case (kind)
			KIND_TICK: begin
				if (n.state != ST_UNINIT) begin
					if (n.tmo != '0) n.tmo = n.tmo - 16'd1;
					if (n.rpt != '0) n.rpt = n.rpt - 16'd1;
					if (n.wsl != '0) n.wsl = n.wsl - 16'd1;
					if (n.cyc != '0) n.cyc = n.cyc - 16'd1;
				end
			end
			KIND_MAIN: begin
				case (n.state)
					ST_REPEAT: begin
						if (n.cyc == '0) begin
							r0  = send_res(n);
							cnt = 2'd1;
							if (n.fast != '0) begin
								n.fast = n.fast - 8'd1;
								n.cyc  = cfg.fast_cycle_ticks;
							end else begin
								n.cyc = cfg.cycle_ticks;
							end
						end
						if (n.rpt == '0) begin
							en  = 1'b1;
							tgt = n.req ? ST_NORMAL : ST_READY;
						end
					end
					ST_NORMAL: begin
						if (n.cyc == '0) begin
							n.cyc = cfg.cycle_ticks;
							r0    = send_res(n);
							cnt   = 2'd1;
						end
						if (n.tmo == '0) n.tmo = cfg.timeout_ticks;
					end
					ST_READY: begin
						if (n.tmo == '0) begin
							en  = 1'b1;
							tgt = ST_PREP;
						end
					end
					ST_PREP: begin
						if (n.wsl == '0) begin
							en    = 1'b1;
							tgt   = ST_SLEEP;
							ind_s = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			KIND_REQ: begin
				n.req = 1'b1;
				if (n.state inside {ST_SLEEP, ST_PREP}) begin
					en  = 1'b1;
					tgt = ST_REPEAT;
				end else if (n.state == ST_READY) begin
					en  = 1'b1;
					tgt = ST_NORMAL;
				end
			end
			KIND_REL: begin
				n.req = 1'b0;
				if (n.state == ST_NORMAL) begin
					en  = 1'b1;
					tgt = ST_READY;
				end
			end
			KIND_RX: begin
				if (((can_id & NM_ID_MASK) == NM_ID_BASE) && (rx_node_id != cfg.own_node_id)) begin
					if (rep) n.rrep = 1'b1;
					case (n.state)
						ST_SLEEP, ST_PREP: begin
							en  = 1'b1;
							tgt = ST_REPEAT;
						end
						ST_REPEAT: begin
							n.tmo = cfg.timeout_ticks;
							if (rep) n.rpt = cfg.repeat_ticks;
						end
						ST_NORMAL, ST_READY: begin
							n.tmo = cfg.timeout_ticks;
							if (rep) begin
								en  = 1'b1;
								tgt = ST_REPEAT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			KIND_INIT: begin
				n = ST_RESET_VAL;
			end
			KIND_DEINIT: begin
				n.state = ST_UNINIT;
			end
			default: begin
			end
		endcase

		if (en) begin
			put_en = (tgt == ST_NORMAL) || ((tgt == ST_REPEAT) && !n.first);
			if (tgt == ST_REPEAT) ind_n = 1'b1;
			n = enter_state(n, cfg, tgt);
			if (put_en) begin
				if (cnt == 2'd0) begin
					r0 = send_res(n);
				end else begin
					r1 = send_res(n);
				end
				cnt = cnt + 2'd1;
			end
		end

		if (cnt == 2'd0) begin
			r0               = '0;
			r0.nm_state      = n.state;
			r0.nm_mode       = n.mode;
			r0.net_requested = n.req;
			cnt              = 2'd1;
		end

		if (cnt == 2'd1) begin
			r0.last                    = 1'b1;
			r0.sleep_indication        = ind_s;
			r0.network_mode_indication = ind_n;
		end else begin
			r1.last                    = 1'b1;
			r1.sleep_indication        = ind_s;
			r1.network_mode_indication = ind_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET_VAL;
		end else if (fire) begin
			st_q <= n;
		end
	end

	assign push.en  = fire;
	assign push.two = (cnt == 2'd2);
	assign push.r0  = r0;
	assign push.r1  = r1;

endmodule
`default_nettype wire

// ----- sv/cannm_res_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cannm_res_fifo
// Result queue: takes one or two results per transaction, delivers one per
// cycle while the reader is ready.
// ----------------------------------------------------------------------------
module cannm_res_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cannm_pkg::push_t    push,
	output logic                space,
	output logic                out_valid,
	input  wire                 out_ready,
	output cannm_pkg::res_t     out_res
);
	import cannm_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;
	logic [FIFO_CW-1:0] n_push;
	logic [FIFO_AW-1:0] wp1;

	assign space     = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign wp1       = wp_q + FIFO_AW'(1);
	assign n_push    = push.en ? (push.two ? FIFO_CW'(2) : FIFO_CW'(1)) : '0;

	always_ff @(posedge clk) begin
		if (push.en) begin
			mem_q[wp_q] <= push.r0;
			if (push.two) mem_q[wp1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(n_push);
			if (pop) rp_q <= rp_q + FIFO_AW'(1);
			cnt_q <= cnt_q + n_push - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
		end
	end

endmodule
`default_nettype wire

// ----- sv/can_network_management_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// can_network_management_fsm
// CAN network-management controller: event in, frame sends and status out.
// ----------------------------------------------------------------------------
// Results: each event's results go into the result queue and leave in order.
// Throughput: one event per cycle while the four-entry result queue has room
// for two; an event with two frame sends yields two results, read out one per
// cycle while the receiver is ready. Reset: asynchronous; state bus sleep,
// timers and request flags cleared, registers at their defaults, queue empty.
// ----------------------------------------------------------------------------
module can_network_management_fsm (
	input  wire         clk,
	input  wire         arst_n,
	cannm_evt_if.sink   evt,
	cannm_res_if.source res,
	cannm_cfg_if.sink   cfg
);
	import cannm_pkg::*;

	cfg_t  cfg_q;
	push_t push;
	res_t  out_res;
	logic  space;
	logic  fire;

	assign evt.ready = space;
	assign fire      = evt.valid && space;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_OWN_NODE_ID:       cfg_q.own_node_id       <= cfg.data[7:0];
				CFG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= cfg.data;
				CFG_REPEAT_TICKS:      cfg_q.repeat_ticks      <= cfg.data;
				CFG_WAIT_SLEEP_TICKS:  cfg_q.wait_sleep_ticks  <= cfg.data;
				CFG_CYCLE_TICKS:       cfg_q.cycle_ticks       <= cfg.data;
				CFG_START_DELAY_TICKS: cfg_q.start_delay_ticks <= cfg.data;
				CFG_FAST_SEND_COUNT:   cfg_q.fast_send_count   <= cfg.data[7:0];
				CFG_FAST_CYCLE_TICKS:  cfg_q.fast_cycle_ticks  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	cannm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.kind       (evt.kind),
		.can_id     (evt.can_id),
		.rx_node_id (evt.rx_node_id),
		.rx_cbv     (evt.rx_cbv),
		.cfg        (cfg_q),
		.push       (push)
	);

	cannm_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_res   (out_res)
	);

	assign res.tx_valid                = out_res.tx_valid;
	assign res.tx_cbv                  = out_res.tx_cbv;
	assign res.nm_state                = out_res.nm_state;
	assign res.nm_mode                 = out_res.nm_mode;
	assign res.net_requested           = out_res.net_requested;
	assign res.sleep_indication        = out_res.sleep_indication;
	assign res.network_mode_indication = out_res.network_mode_indication;
	assign res.last                    = out_res.last;

endmodule
`default_nettype wire

// ----- sv/cannm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cannm_checker
// Port-level checks on the result channel of the network-management block.
// ----------------------------------------------------------------------------
module cannm_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       valid,
	input wire       ready,
	input wire       tx_valid,
	input wire [7:0] tx_cbv,
	input wire [2:0] nm_state,
	input wire [1:0] nm_mode,
	input wire       sleep_indication,
	input wire       last
);
	import cannm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(last) && $stable(tx_cbv))
		else $error("result changed while stalled");

	a_send_net: assert property (@(posedge clk) disable iff (!arst_n)
		valid && tx_valid |-> (nm_mode == MD_NET) &&
			((nm_state == ST_REPEAT) || (nm_state == ST_NORMAL)))
		else $error("frame sent outside network mode");

	a_idle_res: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !tx_valid |-> last && (tx_cbv == 8'd0))
		else $error("non-send result not alone or carries cbv");

	a_sleep_ind: assert property (@(posedge clk) disable iff (!arst_n)
		valid && sleep_indication |-> last && !tx_valid &&
			(nm_state == ST_SLEEP) && (nm_mode == MD_SLEEP))
		else $error("sleep indication without bus sleep");

	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && !last |=> valid && tx_valid)
		else $error("second result of a transaction missing");

endmodule

bind can_network_management_fsm cannm_checker u_cannm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.valid            (res.valid),
	.ready            (res.ready),
	.tx_valid         (res.tx_valid),
	.tx_cbv           (res.tx_cbv),
	.nm_state         (res.nm_state),
	.nm_mode          (res.nm_mode),
	.sleep_indication (res.sleep_indication),
	.last             (res.last)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN network-management controller. Events go in
// through the event channel, with random gaps in some tests. A monitor follows
// each accepted event and register write with its own model of the state
// machine, and compares every result transaction field by field in order.
// Directed sequences cover the filters, uninit handling and timer expiry at
// extreme register values. Then one long output stall fills the block and
// stalls its input, and random traffic runs under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
	import cannm_pkg::*;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 145;

	logic clk = 1'b0;
	logic arst_n;

	cannm_evt_if evt_ch();
	cannm_res_if res_ch();
	cannm_cfg_if cfg_ch();

	can_network_management_fsm dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cfg_t nm_cfg;
	cfg_t active_setup;
	st_t  nm;
	res_t step_out[$];
	res_t status_q[$];
	bit   saw_sleep;
	bit   saw_net;
	int   bad_count = 0;
	bit   tx_idle_on = 1'b0;
	bit   rx_idle_on = 1'b0;
	int   hold_asks = 0;

	// ---------------- model of the controller ----------------

	function automatic void reset_model();
		nm_cfg.own_node_id       = 8'd1;
		nm_cfg.timeout_ticks     = 16'd2000;
		nm_cfg.repeat_ticks      = 16'd1500;
		nm_cfg.wait_sleep_ticks  = 16'd2000;
		nm_cfg.cycle_ticks       = 16'd1000;
		nm_cfg.start_delay_ticks = 16'd100;
		nm_cfg.fast_send_count   = 8'd3;
		nm_cfg.fast_cycle_ticks  = 16'd20;
		active_setup = nm_cfg;
	endfunction

	function automatic void clear_nm();
		nm.state = ST_SLEEP;
		nm.mode  = MD_SLEEP;
		nm.req   = 1'b0;
		nm.rrep  = 1'b0;
		nm.first = 1'b1;
		nm.tmo   = '0;
		nm.rpt   = '0;
		nm.wsl   = '0;
		nm.cyc   = '0;
		nm.fast  = '0;
		nm.cbv   = '0;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			CFG_OWN_NODE_ID:       nm_cfg.own_node_id = data[7:0];
			CFG_TIMEOUT_TICKS:     nm_cfg.timeout_ticks = data;
			CFG_REPEAT_TICKS:      nm_cfg.repeat_ticks = data;
			CFG_WAIT_SLEEP_TICKS:  nm_cfg.wait_sleep_ticks = data;
			CFG_CYCLE_TICKS:       nm_cfg.cycle_ticks = data;
			CFG_START_DELAY_TICKS: nm_cfg.start_delay_ticks = data;
			CFG_FAST_SEND_COUNT:   nm_cfg.fast_send_count = data[7:0];
			CFG_FAST_CYCLE_TICKS:  nm_cfg.fast_cycle_ticks = data;
			default: ;
		endcase
	endfunction

	// one status record per frame sent or no-send step, state at that moment
	function automatic void note_frame(input bit sent);
		res_t r;
		if (step_out.size() >= 2)
			return;
		r = '0;
		r.tx_valid      = sent;
		r.tx_cbv        = sent ? nm.cbv : 8'h00;
		r.nm_state      = nm.state;
		r.nm_mode       = nm.mode;
		r.net_requested = nm.req;
		step_out.push_back(r);
	endfunction

	function automatic void switch_to(input logic [2:0] s);
		nm.state = s;
		case (s)
			ST_SLEEP: begin
				nm.mode = MD_SLEEP;
				nm.cyc  = '0;
				nm.wsl  = '0;
				nm.tmo  = '0;
				nm.rpt  = '0;
				nm.fast = '0;
			end
			ST_PREP: begin
				nm.mode = MD_PREP;
				nm.wsl  = nm_cfg.wait_sleep_ticks;
				nm.cyc  = '0;
				nm.fast = '0;
			end
			ST_REPEAT: begin
				nm.mode = MD_NET;
				nm.rpt  = nm_cfg.repeat_ticks;
				nm.tmo  = nm_cfg.timeout_ticks;
				if (nm.req)
					nm.cbv = nm.cbv | CBV_WAKEUP_BIT;
				else
					nm.cbv = nm.cbv & ~CBV_WAKEUP_BIT;
				if (nm.rrep) begin
					nm.cbv  = nm.cbv | CBV_REPEAT_BIT;
					nm.rrep = 1'b0;
				end else begin
					nm.cbv = nm.cbv & ~CBV_REPEAT_BIT;
				end
				if (nm.first) begin
					nm.cyc   = nm_cfg.start_delay_ticks;
					nm.fast  = nm_cfg.fast_send_count;
					nm.first = 1'b0;
				end else begin
					nm.cyc = nm_cfg.cycle_ticks;
					note_frame(1'b1);
				end
				saw_net = 1'b1;
			end
			ST_NORMAL: begin
				nm.mode = MD_NET;
				nm.tmo  = nm_cfg.timeout_ticks;
				nm.cyc  = nm_cfg.cycle_ticks;
				nm.cbv  = nm.cbv & ~CBV_REPEAT_BIT;
				note_frame(1'b1);
			end
			ST_READY: begin
				nm.mode = MD_NET;
				nm.tmo  = nm_cfg.timeout_ticks;
				nm.cyc  = '0;
				nm.cbv  = nm.cbv & ~CBV_REPEAT_BIT;
			end
			default: ;
		endcase
	endfunction

	function automatic void run_main();
		case (nm.state)
			ST_REPEAT: begin
				if (nm.cyc == 0) begin
					note_frame(1'b1);
					if (nm.fast != 0) begin
						nm.fast = nm.fast - 8'd1;
						nm.cyc  = nm_cfg.fast_cycle_ticks;
					end else begin
						nm.cyc = nm_cfg.cycle_ticks;
					end
				end
				if (nm.rpt == 0)
					switch_to(nm.req ? ST_NORMAL : ST_READY);
			end
			ST_NORMAL: begin
				if (nm.cyc == 0) begin
					nm.cyc = nm_cfg.cycle_ticks;
					note_frame(1'b1);
				end
				if (nm.tmo == 0)
					nm.tmo = nm_cfg.timeout_ticks;
			end
			ST_READY: begin
				if (nm.tmo == 0)
					switch_to(ST_PREP);
			end
			ST_PREP: begin
				if (nm.wsl == 0) begin
					switch_to(ST_SLEEP);
					saw_sleep = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void take_frame(input logic [10:0] id, input logic [7:0] node,
			input logic [7:0] cbv);
		bit rep;
		if ((id & NM_ID_MASK) != NM_ID_BASE)
			return;
		if (node == nm_cfg.own_node_id)
			return;
		rep = (cbv & CBV_REPEAT_BIT) != 0;
		if (rep)
			nm.rrep = 1'b1;
		case (nm.state)
			ST_SLEEP, ST_PREP: switch_to(ST_REPEAT);
			ST_REPEAT: begin
				nm.tmo = nm_cfg.timeout_ticks;
				if (rep)
					nm.rpt = nm_cfg.repeat_ticks;
			end
			ST_NORMAL, ST_READY: begin
				nm.tmo = nm_cfg.timeout_ticks;
				if (rep)
					switch_to(ST_REPEAT);
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_event(input logic [2:0] k, input logic [10:0] id,
			input logic [7:0] node, input logic [7:0] cbv);
		res_t r;
		step_out.delete();
		saw_sleep = 1'b0;
		saw_net = 1'b0;
		case (k)
			KIND_TICK: begin
				if (nm.state != ST_UNINIT) begin
					if (nm.tmo != 0) nm.tmo = nm.tmo - 16'd1;
					if (nm.rpt != 0) nm.rpt = nm.rpt - 16'd1;
					if (nm.wsl != 0) nm.wsl = nm.wsl - 16'd1;
					if (nm.cyc != 0) nm.cyc = nm.cyc - 16'd1;
				end
			end
			KIND_MAIN: begin
				if (nm.state != ST_UNINIT)
					run_main();
			end
			KIND_REQ: begin
				nm.req = 1'b1;
				if (nm.state == ST_SLEEP || nm.state == ST_PREP)
					switch_to(ST_REPEAT);
				else if (nm.state == ST_READY)
					switch_to(ST_NORMAL);
			end
			KIND_REL: begin
				nm.req = 1'b0;
				if (nm.state == ST_NORMAL)
					switch_to(ST_READY);
			end
			KIND_RX:     take_frame(id, node, cbv);
			KIND_INIT:   clear_nm();
			KIND_DEINIT: nm.state = ST_UNINIT;
			default: ;
		endcase
		if (step_out.size() == 0)
			note_frame(1'b0);
		r = step_out.pop_back();
		r.sleep_indication        = saw_sleep;
		r.network_mode_indication = saw_net;
		r.last                    = 1'b1;
		step_out.push_back(r);
		foreach (step_out[i])
			status_q.push_back(step_out[i]);
	endfunction

	// ---------------- checking ----------------

	function automatic string fmt_status(input res_t r);
		return $sformatf({"tx=%0b cbv=%02h state=%0d mode=%0d req=%0b",
			" sleep_ind=%0b net_ind=%0b last=%0b"},
			r.tx_valid, r.tx_cbv, r.nm_state, r.nm_mode, r.net_requested,
			r.sleep_indication, r.network_mode_indication, r.last);
	endfunction

	function automatic void check_status(input res_t got);
		res_t want;
		if (status_q.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("%0t: unexpected result %s", $time, fmt_status(got));
			return;
		end
		want = status_q.pop_front();
		if (got.tx_valid !== want.tx_valid || got.tx_cbv !== want.tx_cbv ||
				got.nm_state !== want.nm_state || got.nm_mode !== want.nm_mode ||
				got.net_requested !== want.net_requested ||
				got.sleep_indication !== want.sleep_indication ||
				got.network_mode_indication !== want.network_mode_indication ||
				got.last !== want.last) begin
			bad_count++;
			if (bad_count <= 10) begin
				$display("%0t: mismatch", $time);
				$display("  expected %s", fmt_status(want));
				$display("  actual   %s", fmt_status(got));
			end
		end
	endfunction

	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				apply_reg(cfg_ch.index, cfg_ch.data);
			if (evt_ch.valid && evt_ch.ready)
				predict_event(evt_ch.kind, evt_ch.can_id, evt_ch.rx_node_id, evt_ch.rx_cbv);
			if (res_ch.valid && res_ch.ready) begin
				got.tx_valid                = res_ch.tx_valid;
				got.tx_cbv                  = res_ch.tx_cbv;
				got.nm_state                = res_ch.nm_state;
				got.nm_mode                 = res_ch.nm_mode;
				got.net_requested           = res_ch.net_requested;
				got.sleep_indication        = res_ch.sleep_indication;
				got.network_mode_indication = res_ch.network_mode_indication;
				got.last                    = res_ch.last;
				check_status(got);
			end
		end
	end

	// ---------------- result sink with random and long stalls ----------------

	initial begin : result_sink
		int rx_wait;
		int holds_done;
		rx_wait = 0;
		holds_done = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready && rx_idle_on)
				rx_wait = $urandom_range(0, 15);
			if (holds_done != hold_asks) begin
				holds_done = hold_asks;
				rx_wait = HOLD_CYCLES;
			end
			if (rx_wait > 0) begin
				res_ch.ready <= 1'b0;
				rx_wait--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- watchdog ----------------

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- drivers ----------------

	task automatic send_event(input logic [2:0] k, input logic [10:0] id,
			input logic [7:0] node, input logic [7:0] cbv);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.kind       <= k;
		evt_ch.can_id     <= id;
		evt_ch.rx_node_id <= node;
		evt_ch.rx_cbv     <= cbv;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	// drop the event valid and wait until every expected result has been checked
	task automatic settle();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_setup(input cfg_t s);
		settle();
		write_reg(CFG_OWN_NODE_ID, {8'h00, s.own_node_id});
		write_reg(CFG_TIMEOUT_TICKS, s.timeout_ticks);
		write_reg(CFG_REPEAT_TICKS, s.repeat_ticks);
		write_reg(CFG_WAIT_SLEEP_TICKS, s.wait_sleep_ticks);
		write_reg(CFG_CYCLE_TICKS, s.cycle_ticks);
		write_reg(CFG_START_DELAY_TICKS, s.start_delay_ticks);
		write_reg(CFG_FAST_SEND_COUNT, {8'h00, s.fast_send_count});
		write_reg(CFG_FAST_CYCLE_TICKS, s.fast_cycle_ticks);
		cfg_ch.valid <= 1'b0;
		active_setup = s;
	endtask

	function automatic cfg_t draw_setup(input int span);
		cfg_t s;
		s.own_node_id       = 8'($urandom_range(0, 255));
		s.timeout_ticks     = 16'($urandom_range(0, span));
		s.repeat_ticks      = 16'($urandom_range(0, span));
		s.wait_sleep_ticks  = 16'($urandom_range(0, span));
		s.cycle_ticks       = 16'($urandom_range(0, span));
		s.start_delay_ticks = 16'($urandom_range(0, span));
		s.fast_send_count   = 8'($urandom_range(0, 4));
		s.fast_cycle_ticks  = 16'($urandom_range(0, span));
		return s;
	endfunction

	// useful is low for items the block drops: foreign id, own node, unused kind
	task automatic send_random_event(output bit useful);
		int pick;
		int sub;
		logic [2:0]  k;
		logic [10:0] id;
		logic [7:0]  node;
		logic [7:0]  cbv;
		pick = $urandom_range(0, 99);
		id   = 11'($urandom_range(0, 2047));
		node = 8'($urandom_range(0, 255));
		cbv  = 8'($urandom_range(0, 255));
		useful = 1'b1;
		if (pick < 30) begin
			k = KIND_TICK;
		end else if (pick < 55) begin
			k = KIND_MAIN;
		end else if (pick < 63) begin
			k = KIND_REQ;
		end else if (pick < 70) begin
			k = KIND_REL;
		end else if (pick < 92) begin
			k = KIND_RX;
			sub = $urandom_range(0, 9);
			if (sub == 1) begin
				while ((id & NM_ID_MASK) == NM_ID_BASE)
					id = 11'($urandom_range(0, 2047));
				useful = 1'b0;
			end else begin
				id = NM_ID_BASE | {3'b000, id[7:0]};
			end
			if (sub == 0) begin
				node = active_setup.own_node_id;
				useful = 1'b0;
			end else if (node == active_setup.own_node_id) begin
				node = node + 8'd1;
			end
		end else if (pick < 96) begin
			k = KIND_INIT;
		end else if (pick < 98) begin
			k = KIND_DEINIT;
		end else begin
			k = KIND_UNUSED;
			useful = 1'b0;
		end
		send_event(k, id, node, cbv);
	endtask

	// ---------------- tests ----------------

	// filters, uninit handling and init under the reset register values
	task automatic test_defaults();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_event(KIND_UNUSED, '0, '0, '0);
		send_event(KIND_RX, 11'h7FF, 8'hFF, 8'hFF);
		send_event(KIND_RX, NM_ID_BASE, 8'd1, CBV_REPEAT_BIT);
		send_event(KIND_RX, NM_ID_BASE | 11'h0FF, 8'd2, CBV_REPEAT_BIT);
		send_event(KIND_REQ, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_REL, '0, '0, '0);
		send_event(KIND_DEINIT, '0, '0, '0);
		send_event(KIND_TICK, '0, '0, '0);
		send_event(KIND_REQ, '0, '0, '0);
		send_event(KIND_RX, NM_ID_BASE, 8'h55, 8'hFF);
		send_event(KIND_INIT, '0, '0, '0);
	endtask

	// all timers zero: every main step expires something, double sends
	task automatic test_zero_timers();
		load_setup('0);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		send_event(KIND_RX, NM_ID_BASE, 8'd0, '0);
		send_event(KIND_REQ, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_REL, '0, '0, '0);
		send_event(KIND_RX, NM_ID_BASE, 8'hAA, CBV_REPEAT_BIT);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_RX, NM_ID_BASE | 11'h0AA, 8'h80, 8'h00);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
	endtask

	task automatic test_max_setup();
		cfg_t s;
		s.own_node_id       = 8'hFF;
		s.timeout_ticks     = 16'hFFFF;
		s.repeat_ticks      = 16'hFFFF;
		s.wait_sleep_ticks  = 16'hFFFF;
		s.cycle_ticks       = 16'hFFFF;
		s.start_delay_ticks = 16'hFFFF;
		s.fast_send_count   = 8'hFF;
		s.fast_cycle_ticks  = 16'hFFFF;
		load_setup(s);
		tx_idle_on = 1'b1;
		send_event(KIND_INIT, '0, '0, '0);
		send_event(KIND_RX, NM_ID_BASE, 8'hFF, CBV_REPEAT_BIT);
		send_event(KIND_RX, NM_ID_BASE, 8'h00, CBV_REPEAT_BIT | CBV_WAKEUP_BIT);
		send_event(KIND_TICK, '0, '0, '0);
		send_event(KIND_MAIN, '0, '0, '0);
	endtask

	// long output stall while events keep coming: queue fills, input stalls
	task automatic test_backpressure();
		bit useful;
		load_setup(draw_setup(3));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_event(KIND_REQ, '0, '0, '0);
		hold_asks++;
		repeat (40) send_random_event(useful);
	endtask

	task automatic test_random_traffic();
		int phase;
		int done;
		bit useful;
		for (phase = 0; phase < 5; phase++) begin
			load_setup(draw_setup(phase == 3 ? 30 : 6));
			tx_idle_on = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			rx_idle_on = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			done = 0;
			while (done < PHASE_ITEMS) begin
				send_random_event(useful);
				if (useful)
					done++;
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		evt_ch.valid      <= 1'b0;
		evt_ch.kind       <= KIND_TICK;
		evt_ch.can_id     <= '0;
		evt_ch.rx_node_id <= '0;
		evt_ch.rx_cbv     <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_OWN_NODE_ID;
		cfg_ch.data       <= '0;
		reset_model();
		clear_nm();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_zero_timers();
		test_max_setup();
		test_backpressure();
		test_random_traffic();
		settle();
		if (bad_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
